FILE: rtl/mbd_pkg.sv
// ---------------------------------------------------------------------------
// mbd_pkg: shared constants and curve functions for the 2x2 mip downsampler
// The curve functions are evaluated at elaboration only, to fill the sRGB
// linearize and threshold tables.
// ---------------------------------------------------------------------------
package mbd_pkg;

  // Configuration register indexes.
  localparam logic REG_NORMAL_MODE = 1'b0;
  localparam logic REG_SRGB_MODE   = 1'b1;

  // Color byte given for a normal block whose vector sum is zero.
  localparam logic [7:0] NORM_ZERO_BYTE = 8'd128;

  localparam longint unsigned Q31_ONE  = 64'h0000_0000_8000_0000;
  localparam longint unsigned Q31_HALF = 64'h0000_0000_4000_0000;

  // Q0.31 product, rounded half up.
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + Q31_HALF) >> 31;
  endfunction

  function automatic longint unsigned pow5(longint unsigned y);
    longint unsigned y2;
    longint unsigned y4;
    y2 = qmul(y, y);
    y4 = qmul(y2, y2);
    return qmul(y4, y);
  endfunction

  // Largest Q0.31 value whose rounded fifth power does not exceed x.
  function automatic longint unsigned root5(longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = Q31_ONE;
    for (int it = 0; it < 64; it++) begin
      if (lo < hi) begin
        mid = lo + (hi - lo + 64'd1) / 2;
        if (pow5(mid) <= x) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

  // Linear-light value of the sRGB level n/510 in Q0.31.
  function automatic longint unsigned lin31(longint unsigned n);
    longint unsigned t;
    longint unsigned sq;
    if (n <= 64'd20) begin
      return ((n * 64'd100 << 31) + 64'd329460) / 64'd658920;
    end
    t = (((64'd1000 * n + 64'd28050) << 31) + 64'd269025) / 64'd538050;
    if (t > Q31_ONE) begin
      t = Q31_ONE;
    end
    sq = qmul(t, t);
    return qmul(sq, root5(sq));
  endfunction

  function automatic longint unsigned to_frac(longint unsigned v, int frac);
    return (v + (64'd1 << (30 - frac))) >> (31 - frac);
  endfunction

  function automatic longint unsigned lin_entry(int i, int frac);
    return to_frac(lin31(64'(2 * i)), frac);
  endfunction

  // Linear value of the midpoint between sRGB codes i-1 and i.
  function automatic longint unsigned thr_entry(int i, int frac);
    if (i == 0) begin
      return 64'd0;
    end
    return to_frac(lin31(64'(2 * i - 1)), frac);
  endfunction

endpackage

FILE: rtl/mip_box_downsample_2x2.sv
// ---------------------------------------------------------------------------
// mip_box_downsample_2x2: 2x2 box filter for RGBA8 mip generation
// Linear, sRGB and normal-map color modes; alpha is always the rounded mean.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle when not stalled; the 19-step square root and
// 9-step divide of the normal path are unrolled into one register stage per bit.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and both mode registers; payload is not reset.
module mip_box_downsample_2x2
  import mbd_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic         cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // red_out, green_out, blue_out, alpha_out
  output logic [31:0]  m_axis_tdata_o
);

  localparam int LW  = LINEAR_FRAC_BITS + 1;
  localparam int NST = 33;

  typedef struct packed {
    logic             nrm;
    logic             srg;
    logic             zero;
    logic [7:0]       alpha;
    logic [2:0][7:0]  lmean;
    logic [2:0][LW-1:0] smean;
    logic [2:0][7:0]  scnt;
    logic [2:0][10:0] s;
    logic [2:0][19:0] sq;
    logic [37:0]      rem;
    logic [18:0]      root;
    logic [2:0][28:0] num;
    logic [20:0]      den;
    logic [2:0][8:0]  quo;
  } stage_t;

  logic [LW-1:0] lin_rom [256];
  logic [LW-1:0] thr_rom [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    assign lin_rom[g] = LW'(lin_entry(g, LINEAR_FRAC_BITS));
    assign thr_rom[g] = LW'(thr_entry(g, LINEAR_FRAC_BITS));
  end

  logic   normal_mode_q, srgb_mode_q;
  logic   adv;
  logic   vld_q [NST];
  stage_t p_q   [NST];
  stage_t p_d   [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_mode_q <= 1'b0;
      srgb_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NORMAL_MODE: normal_mode_q <= cfg_data_i;
        REG_SRGB_MODE:   srgb_mode_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv             = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NST-1];
  assign m_axis_tdata_o  = {p_q[NST-1].alpha, p_q[NST-1].lmean[2],
                            p_q[NST-1].lmean[1], p_q[NST-1].lmean[0]};

  always_comb begin
    logic [9:0]          bsum;
    logic [9:0]          asum;
    logic [LW+1:0]       lsum;
    logic [11:0]         s2;
    logic signed [21:0]  prod;
    logic [21:0]         qsum;
    logic [39:0]         delta;
    logic [7:0]          cand;
    logic signed [20:0]  av;
    logic [19:0]         an;
    logic [29:0]         dsh;
    int                  b;

    // Stage 0: unpack, channel sums, linear and sRGB means, signed sums.
    p_d[0]       = p_q[0];
    p_d[0].nrm   = normal_mode_q;
    p_d[0].srg   = srgb_mode_q;
    asum = 10'(s_axis_tdata_i[31:24]) + 10'(s_axis_tdata_i[63:56])
         + 10'(s_axis_tdata_i[95:88]) + 10'(s_axis_tdata_i[127:120]);
    p_d[0].alpha = 8'((asum + 10'd2) >> 2);
    for (int c = 0; c < 3; c++) begin
      bsum = 10'(s_axis_tdata_i[8*c +: 8]) + 10'(s_axis_tdata_i[32+8*c +: 8])
           + 10'(s_axis_tdata_i[64+8*c +: 8]) + 10'(s_axis_tdata_i[96+8*c +: 8]);
      lsum = (LW+2)'(lin_rom[s_axis_tdata_i[8*c +: 8]])
           + (LW+2)'(lin_rom[s_axis_tdata_i[32+8*c +: 8]])
           + (LW+2)'(lin_rom[s_axis_tdata_i[64+8*c +: 8]])
           + (LW+2)'(lin_rom[s_axis_tdata_i[96+8*c +: 8]]);
      p_d[0].lmean[c] = 8'((bsum + 10'd2) >> 2);
      p_d[0].smean[c] = LW'((lsum + (LW+2)'(2)) >> 2);
      s2 = {1'b0, bsum, 1'b0} - 12'd1020;
      p_d[0].s[c] = s2[10:0];
    end

    for (int j = 1; j < NST; j++) begin
      p_d[j] = p_q[j-1];
      if (j == 1) begin
        for (int c = 0; c < 3; c++) begin
          prod = $signed(p_q[j-1].s[c]) * $signed(p_q[j-1].s[c]);
          p_d[j].sq[c]   = prod[19:0];
          p_d[j].scnt[c] = 8'd0;
        end
      end
      if (j == 2) begin
        qsum = 22'(p_q[j-1].sq[0]) + 22'(p_q[j-1].sq[1]) + 22'(p_q[j-1].sq[2]);
        p_d[j].zero = (qsum == 22'd0);
        p_d[j].rem  = {qsum, 16'd0};
        p_d[j].root = 19'd0;
      end
      // sRGB encode: binary search of the sorted threshold table, one bit a stage.
      if (j >= 2 && j <= 9) begin
        b = 9 - j;
        for (int c = 0; c < 3; c++) begin
          cand = p_q[j-1].scnt[c] | (8'd1 << b);
          if (thr_rom[cand] <= p_q[j-1].smean[c]) begin
            p_d[j].scnt[c] = cand;
          end
        end
      end
      // Square root, one result bit a stage; rem holds the radicand minus root^2.
      if (j >= 3 && j <= 21) begin
        b = 21 - j;
        delta = (40'(p_q[j-1].root) << (b + 1)) + (40'd1 << (2 * b));
        if (40'(p_q[j-1].rem) >= delta) begin
          p_d[j].rem  = 38'(40'(p_q[j-1].rem) - delta);
          p_d[j].root = p_q[j-1].root | (19'd1 << b);
        end
      end
      if (j == 22) begin
        p_d[j].den = {p_q[j-1].root, 2'b00};
        for (int c = 0; c < 3; c++) begin
          av = $signed({2'b00, p_q[j-1].root})
             + ($signed({{10{p_q[j-1].s[c][10]}}, p_q[j-1].s[c]}) <<< 8);
          an = av[20] ? 20'd0 : av[19:0];
          p_d[j].num[c] = 29'(30'(an) * 30'd510) + 29'({p_q[j-1].root, 1'b0});
          p_d[j].quo[c] = 9'd0;
        end
      end
      // Restoring divide, one quotient bit a stage.
      if (j >= 23 && j <= 31) begin
        b = 31 - j;
        dsh = 30'(p_q[j-1].den) << b;
        for (int c = 0; c < 3; c++) begin
          if (30'(p_q[j-1].num[c]) >= dsh) begin
            p_d[j].num[c] = 29'(30'(p_q[j-1].num[c]) - dsh);
            p_d[j].quo[c] = p_q[j-1].quo[c] | (9'd1 << b);
          end
        end
      end
      if (j == 32) begin
        for (int c = 0; c < 3; c++) begin
          if (p_q[j-1].nrm) begin
            if (p_q[j-1].zero) begin
              p_d[j].lmean[c] = NORM_ZERO_BYTE;
            end else if (p_q[j-1].quo[c][8]) begin
              p_d[j].lmean[c] = 8'hFF;
            end else begin
              p_d[j].lmean[c] = p_q[j-1].quo[c][7:0];
            end
          end else if (p_q[j-1].srg) begin
            p_d[j].lmean[c] = p_q[j-1].scnt[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NST; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int j = 1; j < NST; j++) begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < NST; j++) begin
        p_q[j] <= p_d[j];
      end
    end
  end

`ifndef SYNTHESIS
  // The square root remainder never exceeds 2*root once all bits are decided.
  a_sqrt_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[21] |-> (39'(p_q[21].rem) <= 39'({p_q[21].root, 1'b0})))
    else $error("square root remainder out of range");

  // After the last divide stage the red channel's remainder is below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[31] && p_q[31].nrm && !p_q[31].zero)
      |-> (30'(p_q[31].num[0]) < 30'(p_q[31].den)))
    else $error("divide remainder not below divisor");

  // The sRGB code found for red never sits above the mean it encodes.
  a_srgb_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[9] && p_q[9].scnt[0] != 8'd0)
      |-> (thr_rom[p_q[9].scnt[0]] <= p_q[9].smean[0]))
    else $error("sRGB search overshot");

  // A stalled output beat stays in the output register.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && !m_axis_tready_i) |=> vld_q[NST-1])
    else $error("output beat lost during stall");
`endif

endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for the 2x2 RGBA8 mip downsampler
// Sends 2x2 texel blocks in linear, sRGB and normal-map modes, predicts each
// output texel in the testbench and compares every output beat against it.
// ---------------------------------------------------------------------------
module tb
  import mbd_pkg::*;
;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 40;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic         cfg_data_i = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // red_out, green_out, blue_out, alpha_out
  logic [31:0]  m_axis_tdata_o;

  mip_box_downsample_2x2 #(.LINEAR_FRAC_BITS(FRAC)) u_top (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state and the texels still owed by the block.
  logic            normal_on = 1'b0;
  logic            srgb_on = 1'b0;
  int unsigned     decode_lut[256];
  int unsigned     thresh_lut[256];
  logic [31:0]     owed_texels[$];
  int              errors = 0;
  bit              steady = 1'b0;
  bit              hold_req = 1'b0;
  int              hold_left = 0;

  function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  function automatic longint unsigned fifth_pow(longint unsigned y);
    longint unsigned y2, y4;
    y2 = q31_mul(y, y);
    y4 = q31_mul(y2, y2);
    return q31_mul(y4, y);
  endfunction

  // sRGB level n/510 mapped to linear light, Q0.31.
  function automatic longint unsigned curve_q31(longint unsigned n);
    longint unsigned t, sq, lo, hi, mid;
    if (n <= 20) return ((n * 100 << 31) + 329460) / 658920;
    t = (((1000 * n + 28050) << 31) + 269025) / 538050;
    if (t > (64'd1 << 31)) t = 64'd1 << 31;
    sq = q31_mul(t, t);
    lo = 0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (fifth_pow(mid) <= sq) lo = mid;
      else hi = mid - 1;
    end
    return q31_mul(sq, lo);
  endfunction

  function automatic int unsigned to_lut(longint unsigned v);
    return int'((v + (64'd1 << (30 - FRAC))) >> (31 - FRAC));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, c;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] downsample(logic [127:0] blk);
    logic [31:0]     res;
    int              vec[3];
    longint unsigned qsum, len, r;
    longint          a;
    int unsigned     acc, mean, cnt;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) acc += blk[32*i + 8*ch +: 8];
      res[8*ch +: 8] = 8'((acc + 2) >> 2);
    end
    if (normal_on) begin
      qsum = 0;
      for (int ch = 0; ch < 3; ch++) begin
        vec[ch] = 0;
        for (int i = 0; i < 4; i++) vec[ch] += 2 * int'(blk[32*i + 8*ch +: 8]) - 255;
        qsum += longint'(vec[ch] * vec[ch]);
      end
      if (qsum == 0) begin
        for (int ch = 0; ch < 3; ch++) res[8*ch +: 8] = NORM_ZERO_BYTE;
      end else begin
        len = int_sqrt(qsum << 16);
        for (int ch = 0; ch < 3; ch++) begin
          a = longint'(len) + 256 * vec[ch];
          if (a < 0) a = 0;
          r = (510 * longint'(a) + 2 * len) / (4 * len);
          res[8*ch +: 8] = (r > 255) ? 8'd255 : 8'(r);
        end
      end
    end else if (srgb_on) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += decode_lut[blk[32*i + 8*ch +: 8]];
        mean = (acc + 2) >> 2;
        cnt = 0;
        for (int k = 1; k < 256; k++) if (mean >= thresh_lut[k]) cnt++;
        res[8*ch +: 8] = 8'(cnt);
      end
    end
    return res;
  endfunction

  task automatic report(string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  // Output side: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (owed_texels.size() == 0) begin
        report($sformatf("unexpected beat %h", m_axis_tdata_o));
      end else begin
        want = owed_texels.pop_front();
        if (m_axis_tdata_o[7:0] !== want[7:0])
          report($sformatf("red %h, want %h", m_axis_tdata_o[7:0], want[7:0]));
        if (m_axis_tdata_o[15:8] !== want[15:8])
          report($sformatf("green %h, want %h", m_axis_tdata_o[15:8], want[15:8]));
        if (m_axis_tdata_o[23:16] !== want[23:16])
          report($sformatf("blue %h, want %h", m_axis_tdata_o[23:16], want[23:16]));
        if (m_axis_tdata_o[31:24] !== want[31:24])
          report($sformatf("alpha %h, want %h", m_axis_tdata_o[31:24], want[31:24]));
      end
    end
  end

  // Called at a rising edge; returns at the edge where the beat was taken, or after a random idle gap.
  task automatic send_block(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                            logic [31:0] br);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {br, bl, tr, tl};
    do @(posedge clk_i); while (!s_axis_tready_o);
    owed_texels = {owed_texels, downsample({br, bl, tr, tl})};
    if (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Lets the pipeline empty, then writes both mode registers.
  task automatic set_modes(logic nrm, logic srgb);
    s_axis_tvalid_i <= 1'b0;
    while (owed_texels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_NORMAL_MODE;
    cfg_data_i <= nrm;
    @(posedge clk_i);
    cfg_idx_i <= REG_SRGB_MODE;
    cfg_data_i <= srgb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    normal_on = nrm;
    srgb_on = srgb;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_texel();
    return $urandom();
  endfunction

  task automatic test_linear_corners();
    set_modes(1'b0, 1'b0);
    send_block('0, '0, '0, '0);
    send_block('1, '1, '1, '1);
    send_block(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_block(32'h0101_0101, 32'h0101_0101, '0, '0);
    send_block(32'h0302_0100, 32'hFFFE_FDFC, 32'h8081_7F7E, 32'h1234_5678);
  endtask

  task automatic test_srgb_corners();
    set_modes(1'b0, 1'b1);
    send_block('0, '0, '0, '0);
    send_block('1, '1, '1, '1);
    send_block(32'hFF0A_0500, 32'h800A_0AFF, 32'h000B_0A00, 32'h00FF_0B00);
    send_block(32'h4080_C0FF, 32'h4080_C000, 32'h0102_0304, 32'h1415_1617);
  endtask

  task automatic test_normal_corners();
    set_modes(1'b1, 1'b0);
    // Opposite vectors cancel, giving the zero-sum case.
    send_block(32'h0000_0000, 32'h00FF_FFFF, 32'h0000_0000, 32'h00FF_FFFF);
    send_block(32'hFF80_807F, 32'hFF7F_7F80, 32'hFF80_807F, 32'hFF7F_7F80);
    send_block('1, '1, '1, '1);
    send_block('0, '0, '0, '0);
    send_block(32'h00FF_8080, 32'h00FF_8080, 32'h00FF_8080, 32'h00FF_8080);
    send_block(32'h0000_80FF, 32'h0080_0080, 32'h0080_FF80, 32'h00FF_8000);
    send_block(32'h7F80_8080, 32'h807F_8080, 32'h8080_7F80, 32'h8080_807F);
  endtask

  task automatic test_mode_priority();
    set_modes(1'b1, 1'b1);
    send_block(32'h00FF_8080, 32'h0080_FF40, 32'hFF20_4060, 32'h11C0_C0C0);
    send_block('0, '0, '0, '0);
    send_block(32'h0000_0000, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_random_blocks();
    logic [31:0] base;
    for (int phase = 0; phase < 4; phase++) begin
      set_modes(phase[1], phase[0] ^ phase[1]);
      for (int n = 0; n < 500; n++) begin
        steady = (phase == 0 && n >= 100 && n < 250);
        if (phase == 2 && n == 200) hold_req = 1'b1;
        if ($urandom_range(3) == 0) begin
          // Neighbouring texels that differ only slightly.
          base = rand_texel();
          send_block(base, base ^ 32'($urandom_range(7)), base ^ 32'($urandom_range(3) << 8),
                     base ^ 32'($urandom_range(15) << 16));
        end else begin
          send_block(rand_texel(), rand_texel(), rand_texel(), rand_texel());
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      decode_lut[i] = to_lut(curve_q31(2 * i));
      thresh_lut[i] = (i == 0) ? 0 : to_lut(curve_q31(2 * i - 1));
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_linear_corners();
    test_srgb_corners();
    test_normal_corners();
    test_mode_priority();
    test_random_blocks();
    s_axis_tvalid_i <= 1'b0;
    while (owed_texels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("tb: errors");
    $finish;
  end

endmodule
